/* hw/rtl/bsef_pkg.sv */
package bsef_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic signed [63:0] CAP = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0] Q_K0 = ((64'd57573 << FRAC_BITS) + 64'd400) / 64'd800;
  localparam logic [63:0] Q_SEVEN_THIRDS = ((64'd7 << FRAC_BITS) + 64'd1) / 64'd3;
  localparam logic [63:0] Q_28_THIRDS = ((64'd28 << FRAC_BITS) + 64'd1) / 64'd3;

  localparam logic [63:0] FORCE_MAX = 64'h0000_007F_FFFF_FFFF;
  localparam logic [63:0] E_MAX = 64'h0000_00FF_FFFF_FFFF;
  localparam logic signed [27:0] DELTA_HI = 28'sd16777215;
  localparam logic signed [27:0] DELTA_LO = -28'sd16777216;

  localparam int SQ_STEPS = 25;
  localparam int DIV_STEPS = 40;
  localparam logic [50:0] SQ_BIT0 = 51'd1 << 48;

  localparam logic [4:0] OP_IDLE  = 5'd0;
  localparam logic [4:0] OP_SQX   = 5'd1;
  localparam logic [4:0] OP_SQY   = 5'd2;
  localparam logic [4:0] OP_SQZ   = 5'd3;
  localparam logic [4:0] OP_SQI   = 5'd4;
  localparam logic [4:0] OP_SQS   = 5'd5;
  localparam logic [4:0] OP_DELTA = 5'd6;
  localparam logic [4:0] OP_D2    = 5'd7;
  localparam logic [4:0] OP_T7    = 5'd8;
  localparam logic [4:0] OP_POLY  = 5'd9;
  localparam logic [4:0] OP_A     = 5'd10;
  localparam logic [4:0] OP_AD2   = 5'd11;
  localparam logic [4:0] OP_E     = 5'd12;
  localparam logic [4:0] OP_D3    = 5'd13;
  localparam logic [4:0] OP_T28   = 5'd14;
  localparam logic [4:0] OP_SIX1  = 5'd15;
  localparam logic [4:0] OP_SIX2  = 5'd16;
  localparam logic [4:0] OP_INNER = 5'd17;
  localparam logic [4:0] OP_F     = 5'd18;
  localparam logic [4:0] OP_NX    = 5'd19;
  localparam logic [4:0] OP_DVX   = 5'd20;
  localparam logic [4:0] OP_CPX   = 5'd21;
  localparam logic [4:0] OP_NY    = 5'd22;
  localparam logic [4:0] OP_DVY   = 5'd23;
  localparam logic [4:0] OP_CPY   = 5'd24;
  localparam logic [4:0] OP_NZ    = 5'd25;
  localparam logic [4:0] OP_DVZ   = 5'd26;
  localparam logic [4:0] OP_CPZ   = 5'd27;
  localparam logic [4:0] OP_FIN   = 5'd28;
  localparam logic [4:0] OP_LOAD  = 5'd29;

  typedef struct packed {
    logic [4:0] op;
    logic       mul_go;
    logic       exec;
  } bsef_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
  } bsef_stat_t;

  function automatic logic is_mul(input logic [4:0] op);
    return op == OP_SQX || op == OP_SQY || op == OP_SQZ || op == OP_D2 ||
           op == OP_T7 || op == OP_A || op == OP_AD2 || op == OP_E ||
           op == OP_D3 || op == OP_T28 || op == OP_F || op == OP_NX ||
           op == OP_NY || op == OP_NZ;
  endfunction

  function automatic logic [64:0] qround(input logic [127:0] p, input logic neg);
    logic [63:0] r;
    logic ovf;
    ovf = |p[127:64];
    r = (p[63:0] >> FRAC_BITS) + 64'(p[FRAC_BITS-1]);
    if (ovf) r = CAP;
    return {ovf, neg ? -r : r};
  endfunction

  function automatic logic [64:0] sadd(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > CAP) return {1'b1, CAP};
    if (s < -CAP) return {1'b1, -CAP};
    return {1'b0, s};
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

endpackage

/* hw/rtl/bsef_in_if.sv */
interface bsef_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] first_x;
  logic signed [23:0] first_y;
  logic signed [23:0] first_z;
  logic signed [23:0] second_x;
  logic signed [23:0] second_y;
  logic signed [23:0] second_z;
  logic [17:0]        rest_length;
  logic [20:0]        force_constant;
  logic               last_bond;

  modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 rest_length, force_constant, last_bond, input ready);
  modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
               rest_length, force_constant, last_bond, output ready);
endinterface

/* hw/rtl/bsef_out_if.sv */
interface bsef_out_if;
  logic               valid;
  logic               ready;
  logic [39:0]        bond_energy;
  logic [47:0]        energy_total;
  logic signed [39:0] force_x;
  logic signed [39:0] force_y;
  logic signed [39:0] force_z;
  logic signed [24:0] stretch_delta;
  logic               saturated;
  logic               last_out;

  modport source(output valid, bond_energy, energy_total, force_x, force_y, force_z,
                 stretch_delta, saturated, last_out, input ready);
  modport sink(input valid, bond_energy, energy_total, force_x, force_y, force_z,
               stretch_delta, saturated, last_out, output ready);
endinterface

/* hw/rtl/bsef_mul.sv */
module bsef_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [63:0]  ua,
  input  logic [63:0]  ub,
  output logic         done,
  output logic [127:0] prod
);
  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [79:0]  pp;

  always_comb begin
    pp = a_r * {64'd0, b_r[15:0]};
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      a_nxt = ua;
      b_nxt = ub;
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + ({48'd0, pp} << {cnt_r, 4'd0});
      b_nxt = b_r >> 16;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

/* hw/rtl/bsef_ctrl.sv */
module bsef_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsef_pkg::bsef_stat_t stat,
  output bsef_pkg::bsef_cmd_t  cmd
);
  import bsef_pkg::*;

  logic [4:0] op_r, op_nxt;
  logic       ph_r, ph_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_comb begin
    op_nxt = op_r;
    ph_nxt = ph_r;
    cnt_nxt = cnt_r;
    in_ready = 1'b0;
    cmd.op = op_r;
    cmd.mul_go = 1'b0;
    cmd.exec = 1'b0;
    if (op_r == OP_IDLE) begin
      in_ready = 1'b1;
      cmd.op = OP_LOAD;
      if (in_valid) begin
        cmd.exec = 1'b1;
        op_nxt = OP_SQX;
      end
    end else if (is_mul(op_r)) begin
      if (!ph_r) begin
        cmd.mul_go = 1'b1;
        ph_nxt = 1'b1;
      end else if (stat.mul_done) begin
        cmd.exec = 1'b1;
        ph_nxt = 1'b0;
        op_nxt = op_r + 5'd1;
      end
    end else if (op_r == OP_SQS) begin
      cmd.exec = 1'b1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(SQ_STEPS - 1)) begin
        cnt_nxt = '0;
        op_nxt = op_r + 5'd1;
      end
    end else if (op_r == OP_DVX || op_r == OP_DVY || op_r == OP_DVZ) begin
      cmd.exec = 1'b1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_STEPS - 1)) begin
        cnt_nxt = '0;
        op_nxt = op_r + 5'd1;
      end
    end else if (op_r == OP_FIN) begin
      if (stat.out_free) begin
        cmd.exec = 1'b1;
        op_nxt = OP_IDLE;
      end
    end else begin
      cmd.exec = 1'b1;
      op_nxt = op_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_IDLE;
      ph_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      op_r <= op_nxt;
      ph_r <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* hw/rtl/bsef_datapath.sv */
module bsef_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  bsef_in_if.sink              in_bond,
  bsef_out_if.source           out_res,
  input  bsef_pkg::bsef_cmd_t  cmd,
  output bsef_pkg::bsef_stat_t stat
);
  import bsef_pkg::*;

  logic signed [24:0] dx_r, dy_r, dz_r;
  logic [17:0]        r0_r;
  logic [20:0]        kb_r;
  logic               last_r;
  logic [49:0]        sum_r;
  logic [50:0]        sx_r, sres_r, sbit_r;
  logic signed [27:0] delta_r;
  logic signed [63:0] d2_r, t7_r, poly_r, a_r, ad2_r, e_r, d3_r, t28_r, six_r, inner_r;
  logic signed [39:0] force_r;
  logic [63:0]        div_n_r;
  logic [26:0]        div_r_r;
  logic [39:0]        div_q_r;
  logic signed [39:0] cx_r, cy_r, cz_r;
  logic               sat_r;
  logic [47:0]        acc_r;

  logic               out_valid_r;
  logic [39:0]        o_energy_r;
  logic [47:0]        o_total_r;
  logic signed [39:0] o_fx_r, o_fy_r, o_fz_r;
  logic signed [24:0] o_delta_r;
  logic               o_sat_r, o_last_r;

  logic               mul_done;
  logic [127:0]       prod;
  logic [63:0]        ua, ub;
  logic               mneg;
  logic [64:0]        qr, s1, s2;
  logic signed [63:0] delta64;
  logic [25:0]        bond_len;
  logic [50:0]        sq_try;
  logic [26:0]        div_t;
  logic signed [63:0] fneg;
  logic signed [39:0] force_nxt;
  logic               f_sat;
  logic [63:0]        n_val;
  logic               op_sat;
  logic [39:0]        energy;
  logic               e_sat;
  logic [48:0]        tot49;
  logic [47:0]        total;
  logic signed [24:0] dout;
  logic               d_sat;
  logic signed [39:0] comp;
  logic signed [24:0] diff_sel;

  bsef_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.mul_go),
    .ua   (ua),
    .ub   (ub),
    .done (mul_done),
    .prod (prod)
  );

  assign delta64 = {{36{delta_r[27]}}, delta_r};
  assign bond_len = sres_r[25:0];

  always_comb begin
    ua = '0;
    ub = '0;
    mneg = 1'b0;
    diff_sel = dx_r;
    unique case (cmd.op)
      OP_SQX, OP_NX, OP_CPX: diff_sel = dx_r;
      OP_SQY, OP_NY, OP_CPY: diff_sel = dy_r;
      default: diff_sel = dz_r;
    endcase
    unique case (cmd.op)
      OP_SQX, OP_SQY, OP_SQZ: begin
        ua = 64'(diff_sel[24] ? -diff_sel : diff_sel);
        ub = ua;
      end
      OP_D2: begin
        ua = mag64(delta64);
        ub = ua;
      end
      OP_T7: begin
        ua = Q_SEVEN_THIRDS;
        ub = mag64(d2_r);
        mneg = d2_r[63];
      end
      OP_A: begin
        ua = Q_K0;
        ub = 64'(kb_r);
      end
      OP_AD2: begin
        ua = mag64(a_r);
        ub = mag64(d2_r);
        mneg = a_r[63] ^ d2_r[63];
      end
      OP_E: begin
        ua = mag64(ad2_r);
        ub = mag64(poly_r);
        mneg = ad2_r[63] ^ poly_r[63];
      end
      OP_D3: begin
        ua = mag64(d2_r);
        ub = mag64(delta64);
        mneg = d2_r[63] ^ delta64[63];
      end
      OP_T28: begin
        ua = Q_28_THIRDS;
        ub = mag64(d3_r);
        mneg = d3_r[63];
      end
      OP_F: begin
        ua = mag64(a_r);
        ub = mag64(inner_r);
        mneg = a_r[63] ^ inner_r[63];
      end
      OP_NX, OP_NY, OP_NZ: begin
        ua = mag64({{24{force_r[39]}}, force_r});
        ub = 64'(diff_sel[24] ? -diff_sel : diff_sel);
      end
      default: begin
        ua = '0;
        ub = '0;
      end
    endcase
  end

  always_comb begin
    qr = qround(prod, mneg);
    s1 = '0;
    s2 = '0;
    unique case (cmd.op)
      OP_POLY: begin
        s1 = sadd(Q_ONE, -(delta64 <<< 1));
        s2 = sadd(s1[63:0], t7_r);
      end
      OP_SIX1: begin
        s1 = sadd(d2_r, d2_r);
        s2 = sadd(d2_r, s1[63:0]);
      end
      OP_SIX2: begin
        s1 = '0;
        s2 = sadd(six_r, six_r);
      end
      OP_INNER: begin
        s1 = sadd(delta64 <<< 1, -six_r);
        s2 = sadd(s1[63:0], t28_r);
      end
      default: begin
        s1 = '0;
        s2 = '0;
      end
    endcase

    sq_try = sres_r + sbit_r;
    div_t = {div_r_r[25:0], div_n_r[39]};
    n_val = prod[63:0] + 64'(bond_len >> 1);

    fneg = -signed'(qr[63:0]);
    f_sat = mag64(fneg) > FORCE_MAX;
    force_nxt = f_sat ? (fneg[63] ? -40'sh7F_FFFF_FFFF : 40'sh7F_FFFF_FFFF) : fneg[39:0];

    if (bond_len == '0) comp = '0;
    else if (force_r[39] != diff_sel[24]) comp = -div_q_r;
    else comp = div_q_r;

    e_sat = !e_r[63] && (e_r > E_MAX);
    if (e_r[63]) energy = '0;
    else if (e_sat) energy = E_MAX[39:0];
    else energy = e_r[39:0];
    tot49 = {1'b0, acc_r} + 49'(energy);
    total = tot49[48] ? '1 : tot49[47:0];
    d_sat = (delta_r > DELTA_HI) || (delta_r < DELTA_LO);
    if (delta_r > DELTA_HI) dout = DELTA_HI[24:0];
    else if (delta_r < DELTA_LO) dout = DELTA_LO[24:0];
    else dout = delta_r[24:0];

    unique case (cmd.op)
      OP_D2, OP_T7, OP_A, OP_AD2, OP_E, OP_D3, OP_T28: op_sat = qr[64];
      OP_F: op_sat = qr[64] | f_sat;
      OP_POLY, OP_SIX1, OP_INNER: op_sat = s1[64] | s2[64];
      OP_SIX2: op_sat = s2[64];
      default: op_sat = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (cmd.op)
        OP_LOAD: begin
          dx_r <= {in_bond.first_x[23], in_bond.first_x} -
                  {in_bond.second_x[23], in_bond.second_x};
          dy_r <= {in_bond.first_y[23], in_bond.first_y} -
                  {in_bond.second_y[23], in_bond.second_y};
          dz_r <= {in_bond.first_z[23], in_bond.first_z} -
                  {in_bond.second_z[23], in_bond.second_z};
          r0_r <= in_bond.rest_length;
          kb_r <= in_bond.force_constant;
          last_r <= in_bond.last_bond;
        end
        OP_SQX: sum_r <= prod[49:0];
        OP_SQY, OP_SQZ: sum_r <= sum_r + prod[49:0];
        OP_SQI: begin
          sx_r <= {1'b0, sum_r};
          sres_r <= '0;
          sbit_r <= SQ_BIT0;
        end
        OP_SQS: begin
          if (sx_r >= sq_try) begin
            sx_r <= sx_r - sq_try;
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end
        OP_DELTA: delta_r <= signed'({2'b0, bond_len}) - signed'({10'b0, r0_r});
        OP_D2: d2_r <= qr[63:0];
        OP_T7: t7_r <= qr[63:0];
        OP_POLY: poly_r <= s2[63:0];
        OP_A: a_r <= qr[63:0];
        OP_AD2: ad2_r <= qr[63:0];
        OP_E: e_r <= qr[63:0];
        OP_D3: d3_r <= qr[63:0];
        OP_T28: t28_r <= qr[63:0];
        OP_SIX1, OP_SIX2: six_r <= s2[63:0];
        OP_INNER: inner_r <= s2[63:0];
        OP_F: force_r <= force_nxt;
        OP_NX, OP_NY, OP_NZ: begin
          div_n_r <= n_val;
          div_r_r <= {3'b0, n_val[63:40]};
          div_q_r <= '0;
        end
        OP_DVX, OP_DVY, OP_DVZ: begin
          if (div_t >= {1'b0, bond_len}) begin
            div_r_r <= div_t - {1'b0, bond_len};
            div_q_r <= {div_q_r[38:0], 1'b1};
          end else begin
            div_r_r <= div_t;
            div_q_r <= {div_q_r[38:0], 1'b0};
          end
          div_n_r <= div_n_r << 1;
        end
        OP_CPX: cx_r <= comp;
        OP_CPY: cy_r <= comp;
        OP_CPZ: cz_r <= comp;
        OP_FIN: begin
          o_energy_r <= energy;
          o_total_r <= total;
          o_fx_r <= cx_r;
          o_fy_r <= cy_r;
          o_fz_r <= cz_r;
          o_delta_r <= dout;
          o_sat_r <= sat_r | e_sat | tot49[48] | d_sat;
          o_last_r <= last_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      out_valid_r <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.exec && cmd.op == OP_LOAD) sat_r <= 1'b0;
      else if (cmd.exec) sat_r <= sat_r | op_sat;
      if (cmd.exec && cmd.op == OP_FIN) begin
        acc_r <= last_r ? '0 : total;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.out_free = !out_valid_r || out_res.ready;

  assign out_res.valid = out_valid_r;
  assign out_res.bond_energy = o_energy_r;
  assign out_res.energy_total = o_total_r;
  assign out_res.force_x = o_fx_r;
  assign out_res.force_y = o_fy_r;
  assign out_res.force_z = o_fz_r;
  assign out_res.stretch_delta = o_delta_r;
  assign out_res.saturated = o_sat_r;
  assign out_res.last_out = o_last_r;
endmodule

/* hw/rtl/bond_stretch_energy_force_top.sv */
// bond stretch energy and force, one bond per transfer, one result per bond. a 64x64
// multiplier working 16 bits a cycle is shared by fourteen products, the distance comes
// from a 25-step square root, each of the three force components from a 40-step
// restoring divide by the distance, and ten further steps plus the input transfer make
// up the rest of the sequence. a new bond is taken only after the previous one has moved
// to the output register, so a stalled result holds off the input. the energy total
// clears after the last bond.
module bond_stretch_energy_force_top (
  input  logic       clk,
  input  logic       rst_n,
  bsef_in_if.sink    in_bond,
  bsef_out_if.source out_res
);
  import bsef_pkg::*;

  bsef_cmd_t  cmd;
  bsef_stat_t stat;
  logic       in_ready;

  assign in_bond.ready = in_ready;

  bsef_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_bond.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  bsef_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bond(in_bond),
    .out_res(out_res),
    .cmd    (cmd),
    .stat   (stat)
  );
endmodule
